[rtl/dngs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number glyph streamer package
// Shared types, constants and the 5x7 digit font.
// ----------------------------------------------------------------------------
package dngs_pkg;

  localparam int unsigned MagWidth   = 21;
  localparam int unsigned BcdDigits  = 7;
  localparam int unsigned ShownDigits = 6;
  localparam int unsigned FifoDepth  = 2;

  // Back end slot layout: four integer digits, the point, two fraction digits.
  localparam logic [2:0] PointSlot = 3'd4;
  localparam logic [2:0] LastSlot  = 3'd6;
  localparam logic [3:0] LastSub   = 4'd9;
  localparam logic [3:0] PointSub  = 4'd1;

  // Byte positions within one digit.
  localparam logic [3:0] SubPage    = 4'd0;
  localparam logic [3:0] SubColLo   = 4'd1;
  localparam logic [3:0] SubColHi   = 4'd2;
  localparam logic [3:0] SubGlyph0  = 4'd3;
  localparam logic [3:0] SubGlyph4  = 4'd7;

  localparam logic [7:0] PageCmdBase = 8'hB0;
  localparam logic [3:0] ColHiCmd    = 4'h1;
  localparam logic [7:0] PointByte   = 8'hFF;
  localparam logic [7:0] BlankByte   = 8'h00;

  localparam logic [7:0] DigitPitch  = 8'd7;
  localparam logic [7:0] PointPitch  = 8'd2;

  typedef enum logic [1:0] {
    FrIdle,
    FrConv,
    FrPush
  } front_state_e;

  typedef enum logic {
    BkIdle,
    BkRun
  } back_state_e;

  // One classified item: digits left to right, page and first column.
  typedef struct packed {
    logic [ShownDigits-1:0][3:0] digits;
    logic [2:0]                  page;
    logic [7:0]                  column;
  } entry_t;

  // Font column k (0 = leftmost) of a decimal digit.
  function automatic logic [7:0] glyph_col(input logic [3:0] digit, input logic [2:0] k);
    logic [39:0] cols;
    begin
      unique case (digit)
        4'd0:    cols = 40'h3E_51_49_45_3E;
        4'd1:    cols = 40'h00_42_7F_40_00;
        4'd2:    cols = 40'h42_61_51_49_46;
        4'd3:    cols = 40'h21_41_45_4B_31;
        4'd4:    cols = 40'h18_14_12_7F_10;
        4'd5:    cols = 40'h27_45_45_45_39;
        4'd6:    cols = 40'h3C_4A_49_49_30;
        4'd7:    cols = 40'h01_71_09_05_03;
        4'd8:    cols = 40'h36_49_49_49_36;
        4'd9:    cols = 40'h06_49_49_29_1E;
        default: cols = 40'h0;
      endcase
      unique case (k)
        3'd0:    glyph_col = cols[39:32];
        3'd1:    glyph_col = cols[31:24];
        3'd2:    glyph_col = cols[23:16];
        3'd3:    glyph_col = cols[15:8];
        3'd4:    glyph_col = cols[7:0];
        default: glyph_col = 8'h00;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

[rtl/dngs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number glyph streamer front end
// Takes the magnitude apart into decimal digits with a shift-and-add-3
// converter, one bit per cycle, and hands the digit set to the queue.
// ----------------------------------------------------------------------------
module dngs_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [20:0]    value_hundredths_i,
  input  wire logic [2:0]            page_i,
  input  wire logic [7:0]            start_column_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output dngs_pkg::entry_t           entry_o
);

  localparam int unsigned CntWidth = $clog2(dngs_pkg::MagWidth);
  localparam logic [CntWidth-1:0] LastBit = CntWidth'(dngs_pkg::MagWidth - 1);

  dngs_pkg::front_state_e state_q, state_d;

  logic [dngs_pkg::MagWidth-1:0]     bin_q, bin_d;
  logic [4*dngs_pkg::BcdDigits-1:0]  bcd_q, bcd_d, bcd_adj;
  logic [CntWidth-1:0]               cnt_q, cnt_d;
  logic                              neg_q;
  logic [2:0]                        page_q;
  logic [7:0]                        column_q;
  logic                              accept;
  logic [dngs_pkg::MagWidth-1:0]     mag;

  assign accept = start && !busy;
  assign mag    = value_hundredths_i[20] ? (~value_hundredths_i + 21'd1)
                                         : value_hundredths_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dngs_pkg::FrIdle: if (start) state_d = dngs_pkg::FrConv;
      dngs_pkg::FrConv: if (cnt_q == LastBit) state_d = dngs_pkg::FrPush;
      dngs_pkg::FrPush: if (!full_i) state_d = dngs_pkg::FrIdle;
      default:          state_d = dngs_pkg::FrIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    busy   = (state_q != dngs_pkg::FrIdle);
    push_o = (state_q == dngs_pkg::FrPush) && !full_i;
  end

  always_comb begin
    for (int i = 0; i < dngs_pkg::BcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                     : bcd_q[4*i +: 4];
    end
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (accept) begin
      bin_d = mag;
      bcd_d = '0;
      cnt_d = '0;
    end else if (state_q == dngs_pkg::FrConv) begin
      {bcd_d, bin_d} = {bcd_adj[4*dngs_pkg::BcdDigits-2:0], bin_q, 1'b0};
      cnt_d = cnt_q + CntWidth'(1);
    end
  end

  // Digits of the converted magnitude: d6..d2 integer part, d1..d0 fraction.
  always_comb begin
    entry_o.page   = page_q;
    entry_o.column = column_q;
    if (neg_q) begin
      entry_o.digits[3:0] = '0;
    end else if (bcd_q[27:24] != 4'd0) begin
      entry_o.digits[3:0] = {4{4'd9}};
    end else begin
      entry_o.digits[0] = bcd_q[23:20];
      entry_o.digits[1] = bcd_q[19:16];
      entry_o.digits[2] = bcd_q[15:12];
      entry_o.digits[3] = bcd_q[11:8];
    end
    entry_o.digits[4] = bcd_q[7:4];
    entry_o.digits[5] = bcd_q[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dngs_pkg::FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    if (accept) begin
      neg_q    <= value_hundredths_i[20];
      page_q   <= page_i;
      column_q <= start_column_i;
    end
  end

endmodule
`default_nettype wire

[rtl/dngs_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number glyph streamer queue
// Short register queue of digit sets between the front and back ends.
// ----------------------------------------------------------------------------
module dngs_fifo #(
  parameter int unsigned DEPTH = dngs_pkg::FifoDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dngs_pkg::entry_t entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output dngs_pkg::entry_t      head_o
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

  dngs_pkg::entry_t    mem_q [DEPTH];
  logic [PtrWidth-1:0] wr_q, rd_q;
  logic [CntWidth-1:0] cnt_q;

  assign full_o  = (cnt_q == CntWidth'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrWidth'(1);
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrWidth'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntWidth'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule
`default_nettype wire

[rtl/dngs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number glyph streamer back end
// Walks one digit set through its 62 display bytes, one beat a cycle.
// ----------------------------------------------------------------------------
module dngs_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire dngs_pkg::entry_t head_i,
  output logic                  pop_o,
  output logic                  strobe,
  output logic [7:0]            out_byte_o,
  output logic                  is_data_o,
  output logic                  last_o
);

  dngs_pkg::back_state_e state_q, state_d;

  dngs_pkg::entry_t entry_q;
  logic [2:0]       slot_q;
  logic [3:0]       sub_q;
  logic [7:0]       col_q;
  logic             run_end;
  logic [2:0]       digit_idx;
  logic [3:0]       digit;
  logic [7:0]       byte_d;
  logic             data_d;
  logic             strobe_q;
  logic [7:0]       byte_q;
  logic             data_q;
  logic             last_q;

  assign run_end = (slot_q == dngs_pkg::LastSlot) && (sub_q == dngs_pkg::LastSub);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dngs_pkg::BkIdle: if (!empty_i) state_d = dngs_pkg::BkRun;
      dngs_pkg::BkRun:  if (run_end && empty_i) state_d = dngs_pkg::BkIdle;
      default:          state_d = dngs_pkg::BkIdle;
    endcase
  end

  // Outputs: pop the queue head while idle or at the last beat of a run.
  always_comb begin
    pop_o = !empty_i && ((state_q == dngs_pkg::BkIdle) || run_end);
  end

  // The point takes slot four, so fraction digits sit one slot higher.
  assign digit_idx = (slot_q > dngs_pkg::PointSlot) ? (slot_q - 3'd1) : slot_q;
  assign digit     = entry_q.digits[digit_idx];

  always_comb begin
    byte_d = dngs_pkg::BlankByte;
    data_d = 1'b1;
    if (slot_q == dngs_pkg::PointSlot) begin
      byte_d = (sub_q == 4'd0) ? dngs_pkg::PointByte : dngs_pkg::BlankByte;
    end else begin
      priority if (sub_q == dngs_pkg::SubPage) begin
        byte_d = dngs_pkg::PageCmdBase + {5'd0, entry_q.page};
        data_d = 1'b0;
      end else if (sub_q == dngs_pkg::SubColLo) begin
        byte_d = {4'h0, col_q[3:0]};
        data_d = 1'b0;
      end else if (sub_q == dngs_pkg::SubColHi) begin
        byte_d = {dngs_pkg::ColHiCmd, col_q[7:4]};
        data_d = 1'b0;
      end else if (sub_q <= dngs_pkg::SubGlyph4) begin
        byte_d = dngs_pkg::glyph_col(digit, 3'(sub_q - dngs_pkg::SubGlyph0));
      end else begin
        byte_d = dngs_pkg::BlankByte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dngs_pkg::BkIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == dngs_pkg::BkRun);
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    data_q <= data_d;
    last_q <= run_end;
    if (pop_o) begin
      entry_q <= head_i;
      slot_q  <= '0;
      sub_q   <= '0;
      col_q   <= head_i.column;
    end else if (state_q == dngs_pkg::BkRun) begin
      if (slot_q == dngs_pkg::PointSlot) begin
        if (sub_q == dngs_pkg::PointSub) begin
          slot_q <= slot_q + 3'd1;
          sub_q  <= '0;
          col_q  <= col_q + dngs_pkg::PointPitch;
        end else begin
          sub_q <= sub_q + 4'd1;
        end
      end else if (sub_q == dngs_pkg::LastSub) begin
        slot_q <= slot_q + 3'd1;
        sub_q  <= '0;
        col_q  <= col_q + dngs_pkg::DigitPitch;
      end else begin
        sub_q <= sub_q + 4'd1;
      end
    end
  end

  assign strobe     = strobe_q;
  assign out_byte_o = byte_q;
  assign is_data_o  = data_q;
  assign last_o     = strobe_q && last_q;

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> is_data_o)
    else $error("final beat of a run is not a data byte");

  a_run_opens_with_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> (!strobe || (!is_data_o && out_byte_o[7:4] == dngs_pkg::PageCmdBase[7:4])))
    else $error("run following a final beat does not open with a page command");

  a_pop_only_at_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && state_q == dngs_pkg::BkRun) |-> run_end)
    else $error("new digit set loaded in the middle of a run");

endmodule
`default_nettype wire

[rtl/decimal_number_glyph_streamer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number glyph streamer
// Draws a value in hundredths as six 5x7 digits for a page-addressed display.
// ----------------------------------------------------------------------------
// Usage: drive value_hundredths_i, page_i and start_column_i and raise start;
// the item is taken at a rising edge with start high and busy low. Each item
// becomes 62 beats on out_byte_o, is_data_o and last_o, each valid for one
// cycle while strobe is high; last_o marks the 62nd beat. The receiver cannot
// stall, and none is needed: beats of one item come on consecutive cycles.
// The front end converts the magnitude to decimal one bit per cycle and keeps
// busy high from the start until the digit set is pushed, which waits while
// the queue is full. The back end emits one beat per cycle within a run, and
// its byte sequencer sets the sustained throughput; its next run follows the
// last beat with no gap when the queue holds a digit set. Up to FIFO_DEPTH
// converted items wait in the queue. Reset empties the queue, returns both
// ends to idle and clears strobe.
// ----------------------------------------------------------------------------
module decimal_number_glyph_streamer_top #(
  parameter int unsigned FIFO_DEPTH = dngs_pkg::FifoDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [20:0] value_hundredths_i,
  input  wire logic [2:0]         page_i,
  input  wire logic [7:0]         start_column_i,
  output logic                    strobe,
  output logic [7:0]              out_byte_o,
  output logic                    is_data_o,
  output logic                    last_o
);

  dngs_pkg::entry_t push_entry;
  dngs_pkg::entry_t head_entry;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  dngs_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .value_hundredths_i (value_hundredths_i),
    .page_i             (page_i),
    .start_column_i     (start_column_i),
    .full_i             (full),
    .push_o             (push),
    .entry_o            (push_entry)
  );

  dngs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_entry)
  );

  dngs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head_entry),
    .pop_o      (pop),
    .strobe     (strobe),
    .out_byte_o (out_byte_o),
    .is_data_o  (is_data_o),
    .last_o     (last_o)
  );

endmodule
`default_nettype wire

[bench/dngs_glyph_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph stream checker
// Watches the command and beat channels of the glyph streamer. For every
// accepted number it builds the 62 display bytes it expects and compares them
// in order with the beats that the block sends out.
// ----------------------------------------------------------------------------
module dngs_glyph_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic signed [20:0] value_hundredths_i,
  input  wire logic [2:0]         page_i,
  input  wire logic [7:0]         start_column_i,
  input  wire logic               strobe_i,
  input  wire logic [7:0]         out_byte_i,
  input  wire logic               is_data_i,
  input  wire logic               last_i,
  output int unsigned             pending_o,
  output int unsigned             errors_o
);

  localparam int unsigned RunBeats = 62;

  // Five font columns per digit, leftmost column in the top byte.
  localparam logic [0:9][39:0] DigitFont = {
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46,
    40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39,
    40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36,
    40'h06_49_49_29_1E
  };

  typedef struct packed {
    logic [7:0] code;
    logic       is_data;
    logic       last;
  } display_beat_t;

  display_beat_t expected_bytes[$];
  display_beat_t want;
  int unsigned   run_beats;
  int unsigned   mismatches;

  assign errors_o = mismatches;

  task automatic push_byte(input logic [7:0] code, input logic is_data);
    display_beat_t b;
    b.code    = code;
    b.is_data = is_data;
    b.last    = (run_beats == RunBeats - 1);
    expected_bytes.push_back(b);
    run_beats++;
  endtask

  task automatic push_digit(input logic [3:0] digit, input logic [2:0] page,
                            input logic [7:0] col);
    push_byte(dngs_pkg::PageCmdBase + {5'd0, page}, 1'b0);
    push_byte({4'h0, col[3:0]}, 1'b0);
    push_byte({dngs_pkg::ColHiCmd, col[7:4]}, 1'b0);
    for (int k = 0; k < 5; k++) begin
      push_byte(DigitFont[digit][39 - 8*k -: 8], 1'b1);
    end
    push_byte(dngs_pkg::BlankByte, 1'b1);
    push_byte(dngs_pkg::BlankByte, 1'b1);
  endtask

  // Negative numbers show a zero integer part; the fraction still comes from
  // the magnitude. Integer parts beyond four digits saturate at 9999.
  task automatic predict_number(input logic signed [20:0] value, input logic [2:0] page,
                                input logic [7:0] col);
    logic [21:0] magnitude;
    logic [21:0] whole;
    logic [21:0] frac;
    magnitude = value[20] ? (22'h200000 - {1'b0, value}) : {1'b0, value};
    whole     = value[20] ? 22'd0 : magnitude / 22'd100;
    frac      = magnitude % 22'd100;
    if (whole > 22'd9999) begin
      whole = 22'd9999;
    end
    run_beats = 0;
    push_digit(4'((whole / 1000) % 10), page, col);
    push_digit(4'((whole / 100) % 10), page, col + 8'd7);
    push_digit(4'((whole / 10) % 10), page, col + 8'd14);
    push_digit(4'(whole % 10), page, col + 8'd21);
    push_byte(dngs_pkg::PointByte, 1'b1);
    push_byte(dngs_pkg::BlankByte, 1'b1);
    push_digit(4'(frac / 10), page, col + 8'd30);
    push_digit(4'(frac % 10), page, col + 8'd37);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        predict_number(value_hundredths_i, page_i, start_column_i);
      end
      if (strobe_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected beat: out_byte %02h is_data %0b last %0b",
                 out_byte_i, is_data_i, last_i);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_i !== want.code) begin
            $error("out_byte: expected %02h, got %02h", want.code, out_byte_i);
            mismatches++;
          end
          if (is_data_i !== want.is_data) begin
            $error("is_data: expected %0b, got %0b", want.is_data, is_data_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            mismatches++;
          end
        end
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule
`default_nettype wire

[bench/tb_decimal_number_glyph_streamer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph streamer testbench
// Sends directed and random numbers with random start gaps; a checker beside
// the block predicts and compares every display beat, and this module reports.
// ----------------------------------------------------------------------------
module tb_decimal_number_glyph_streamer_top;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomItems = 82;
  localparam int unsigned DrainCycles = 64;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [20:0] value_hundredths;
  logic [2:0]         page;
  logic [7:0]         start_column;
  logic               strobe;
  logic [7:0]         out_byte;
  logic               is_data;
  logic               last;
  int unsigned        pending;
  int unsigned        mismatches;
  int unsigned        quiet_cycles;
  bit                 idling_on;

  decimal_number_glyph_streamer_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .value_hundredths_i (value_hundredths),
    .page_i             (page),
    .start_column_i     (start_column),
    .strobe             (strobe),
    .out_byte_o         (out_byte),
    .is_data_o          (is_data),
    .last_o             (last)
  );

  dngs_glyph_checker u_glyph_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .value_hundredths_i (value_hundredths),
    .page_i             (page),
    .start_column_i     (start_column),
    .strobe_i           (strobe),
    .out_byte_i         (out_byte),
    .is_data_i          (is_data),
    .last_i             (last),
    .pending_o          (pending),
    .errors_o           (mismatches)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Ends the run when neither a command nor a beat has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("** decimal_number_glyph_streamer_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a following number can go out without a gap.
  task automatic draw_number(input logic signed [20:0] v, input logic [2:0] p,
                             input logic [7:0] c);
    while (idling_on && ($urandom_range(99) < 36)) begin
      start            = 1'b0;
      value_hundredths = 21'($urandom);
      page             = 3'($urandom);
      start_column     = 8'($urandom);
      @(negedge clk_i);
    end
    start            = 1'b1;
    value_hundredths = v;
    page             = p;
    start_column     = c;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  function automatic logic signed [20:0] random_value();
    if ($urandom_range(7) == 0) begin
      return 21'($urandom);
    end
    return 21'($urandom_range(1999998) - 999999);
  endfunction

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    value_hundredths = '0;
    page             = '0;
    start_column     = '0;
    idling_on        = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    draw_number(21'sd0, 3'd0, 8'd0);
    draw_number(21'sd999999, 3'd7, 8'd255);
    draw_number(-21'sd999999, 3'd0, 8'd0);
    draw_number(21'sd1, 3'd3, 8'd17);
    draw_number(-21'sd1, 3'd4, 8'd200);
    draw_number(21'sd99, 3'd5, 8'd225);
    draw_number(-21'sd99, 3'd6, 8'd226);
    draw_number(21'sd100, 3'd1, 8'd249);
    draw_number(-21'sd100, 3'd2, 8'd128);
    draw_number(21'sd123456, 3'd7, 8'd240);
    draw_number(21'sd789, 3'd0, 8'd15);
    draw_number(21'sd987654, 3'd1, 8'd16);
    draw_number(21'sd31023, 3'd2, 8'd100);
    // Largest positive code saturates the integer part; the most negative
    // code has a magnitude one past the positive range.
    draw_number(21'h0FFFFF, 3'd3, 8'd50);
    draw_number(21'h100000, 3'd4, 8'd60);
    draw_number(21'sd999900, 3'd5, 8'd0);
    draw_number(-21'sd12345, 3'd6, 8'd230);
    draw_number(21'sd555555, 3'd0, 8'd219);

    for (int n = 0; n < RandomItems; n++) begin
      idling_on = !(n >= 40 && n < 70);
      draw_number(random_value(), 3'($urandom), 8'($urandom));
    end
    start = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** decimal_number_glyph_streamer_top: PASSED **");
    end else begin
      $display("** decimal_number_glyph_streamer_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/dngs_pkg.sv
rtl/dngs_front.sv
rtl/dngs_fifo.sv
rtl/dngs_back.sv
rtl/decimal_number_glyph_streamer_top.sv
bench/dngs_glyph_checker.sv
bench/tb_decimal_number_glyph_streamer_top.sv
